@@ rtl/clx_pkg.sv @@
// Shared types, constants and helper functions for the character stream lexer.
// No dependencies; imported by clx_core, clx_tok_fifo and char_stream_lexer_unit.
package clx_pkg;

    // Word limits
    localparam int MAX_WORD   = 511;
    localparam int LEN_W      = 9;
    localparam int HEAD_BYTES = 8;
    localparam int HEAD_W     = 64;
    localparam int LINE_W     = 16;
    localparam int KIND_W     = 4;

    // Token queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Keyword table: text is packed with the first byte lowest
    localparam int NKW = 7;
    localparam logic [HEAD_W-1:0] KW_TEXT [NKW] = '{
        64'h0000_0000_0074_6E69,  // int
        64'h0000_0000_7261_6863,  // char
        64'h0000_676E_6972_7473,  // string
        64'h0000_0074_616F_6C66,  // float
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6573_6C65,  // else
        64'h0000_0000_0000_6E66   // fn
    };
    localparam logic [2:0] KW_LEN [NKW] = '{3'd3, 3'd4, 3'd6, 3'd5, 3'd2, 3'd4, 3'd2};

    typedef enum logic [KIND_W-1:0] {
        K_VARTYPE  = 4'd0,
        K_IF       = 4'd1,
        K_ELSE     = 4'd2,
        K_FUNCTION = 4'd3,
        K_NAME     = 4'd4,
        K_NUMBER   = 4'd5,
        K_LPAREN   = 4'd6,
        K_RPAREN   = 4'd7,
        K_LBRACE   = 4'd8,
        K_RBRACE   = 4'd9,
        K_COLON    = 4'd10,
        K_EQUALS   = 4'd11,
        K_OTHER    = 4'd12
    } kind_t;

    localparam kind_t KW_KIND [NKW] = '{
        K_VARTYPE, K_VARTYPE, K_VARTYPE, K_VARTYPE, K_IF, K_ELSE, K_FUNCTION
    };

    // Character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;

    // One output token
    typedef struct packed {
        kind_t              kind;
        logic [LINE_W-1:0]  line_no;
        logic [LEN_W-1:0]   len;
        logic [HEAD_W-1:0]  head;
        logic               last;
    } tok_t;

    // Up to two tokens produced by one character
    typedef struct packed {
        logic [1:0] n;
        tok_t       tok0;
        tok_t       tok1;
    } push_t;

    // Running word contents
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [HEAD_W-1:0] head;
        logic [NKW-1:0]    alive;
    } word_t;

endpackage

@@ rtl/clx_core.sv @@
// Lexer core: running word state, keyword match and token formation.
// Depends on clx_pkg.
module clx_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    ch,
    output clx_pkg::push_t push
);
    import clx_pkg::*;

    typedef enum logic [2:0] {
        MODE_NONE = 3'b001,
        MODE_NUM  = 3'b010,
        MODE_NAME = 3'b100
    } mode_t;

    localparam word_t WORD_EMPTY = '{len: '0, head: '0, alive: '1};

    mode_t              mode_reg, mode_next;
    logic               period_reg, period_next;
    word_t              word_reg, word_next;
    logic [LINE_W-1:0]  line_reg, line_next;

    logic  blank, digit, name_start, word_char, cont;
    kind_t word_kind;
    tok_t  word_tok, sym_tok;
    push_t push_c;

    // Append one character to a word
    function automatic word_t push_char(word_t base, logic [7:0] c);
        word_t w;
        w = base;
        if (base.len < LEN_W'(HEAD_BYTES))
        begin
            w.head[8*base.len[2:0] +: 8] = c;
        end
        for (int i = 0; i < NKW; i++)
        begin
            if (base.len >= LEN_W'(KW_LEN[i]) || KW_TEXT[i][8*base.len[2:0] +: 8] != c)
            begin
                w.alive[i] = 1'b0;
            end
        end
        w.len = (base.len < LEN_W'(MAX_WORD)) ? base.len + 1'b1 : LEN_W'(MAX_WORD);
        return w;
    endfunction

    function automatic kind_t symbol_kind(logic [7:0] c);
        kind_t k;
        case (c)
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_COLON:  k = K_COLON;
            CH_EQUALS: k = K_EQUALS;
            default:   k = K_OTHER;
        endcase
        return k;
    endfunction

    always_comb
    begin
        blank      = (ch == CH_SPACE) || (ch == CH_NL);
        digit      = ch inside {[8'h30:8'h39]};
        name_start = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (ch == CH_UNDER);
        word_char  = digit || name_start;
        if (mode_reg == MODE_NUM)
        begin
            cont = digit || (ch == CH_PERIOD && !period_reg);
        end
        else
        begin
            cont = word_char;
        end

        // Lowest-index live keyword of matching length wins
        word_kind = K_NAME;
        for (int i = NKW - 1; i >= 0; i--)
        begin
            if (word_reg.alive[i] && word_reg.len == LEN_W'(KW_LEN[i]))
            begin
                word_kind = KW_KIND[i];
            end
        end
        if (mode_reg == MODE_NUM)
        begin
            word_kind = K_NUMBER;
        end

        word_tok = '{kind: word_kind, line_no: line_reg, len: word_reg.len,
                     head: word_reg.head, last: 1'b0};
        sym_tok  = '{kind: symbol_kind(ch), line_no: line_reg, len: LEN_W'(1),
                     head: HEAD_W'(ch), last: 1'b0};

        mode_next   = mode_reg;
        period_next = period_reg;
        word_next   = word_reg;
        push_c      = '{n: 2'd0, tok0: sym_tok, tok1: sym_tok};

        case (mode_reg)
            MODE_NONE:
            begin
                if (word_char)
                begin
                    mode_next   = digit ? MODE_NUM : MODE_NAME;
                    period_next = 1'b0;
                    word_next   = push_char(WORD_EMPTY, ch);
                end
                else if (!blank)
                begin
                    push_c.n = 2'd1;
                end
            end
            MODE_NUM, MODE_NAME:
            begin
                if (cont)
                begin
                    if (ch == CH_PERIOD)
                    begin
                        period_next = 1'b1;
                    end
                    word_next = push_char(word_reg, ch);
                end
                else
                begin
                    push_c.tok0 = word_tok;
                    push_c.n    = 2'd1;
                    mode_next   = MODE_NONE;
                    period_next = 1'b0;
                    word_next   = WORD_EMPTY;
                    if (mode_reg == MODE_NUM && name_start)
                    begin
                        // letter closes a number and opens a name
                        mode_next = MODE_NAME;
                        word_next = push_char(WORD_EMPTY, ch);
                    end
                    else if (!blank)
                    begin
                        push_c.n = 2'd2;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_NONE;
            end
        endcase

        push_c.tok0.last = (push_c.n == 2'd1);
        push_c.tok1.last = 1'b1;
        if (!fire)
        begin
            push_c.n = 2'd0;
        end

        line_next = line_reg;
        if (ch == CH_NL && line_reg != '1)
        begin
            line_next = line_reg + 1'b1;
        end
    end

    assign push = push_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            period_reg <= 1'b0;
            word_reg   <= WORD_EMPTY;
            line_reg   <= LINE_W'(1);
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            period_reg <= period_next;
            word_reg   <= word_next;
            line_reg   <= line_next;
        end
    end

`ifndef SYNTH
    // two tokens: a word, then a symbol
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> (push.tok0.kind == K_NAME || push.tok0.kind == K_NUMBER ||
                            push.tok0.kind == K_VARTYPE || push.tok0.kind == K_IF ||
                            push.tok0.kind == K_ELSE || push.tok0.kind == K_FUNCTION)
                           && push.tok1.len == LEN_W'(1))
        else $error("token pair out of order");
    a_open_word_len: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_NONE |-> word_reg.len != '0)
        else $error("open word with zero length");
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line count reached zero");
    a_period_num: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg |-> mode_reg == MODE_NUM)
        else $error("period flag outside a number");
`endif

endmodule

@@ rtl/clx_tok_fifo.sv @@
// Four-entry token queue; takes up to two tokens a cycle, gives one while out_ready is high.
// Depends on clx_pkg.
module clx_tok_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  clx_pkg::push_t push,
    output logic          room,
    output logic          out_valid,
    input  logic          out_ready,
    output clx_pkg::tok_t out_tok
);
    import clx_pkg::*;

    tok_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];
    // room for a full pair, ignoring any pop this cycle
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_1  = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> (count_reg + CNT_W'(push.n)) <= CNT_W'(FIFO_DEPTH))
        else $error("token queue overflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("token queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != CNT_W'(FIFO_DEPTH) |->
            PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ rtl/char_stream_lexer_unit.sv @@
// Character stream lexer, top level: input register, lexer core, token queue.
// Depends on clx_pkg, clx_core and clx_tok_fifo.
//
//   channel | signals                                       | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_ready, ch                        | request in
//   out     | out_valid, out_ready, kind, line_no,          | request out
//           | lexeme_len, lexeme_head, last                 |
//
// A request lands in the input register and is lexed once the queue can take
// a pair, pushing zero, one or two tokens into a four-entry queue; the first
// token can leave in the cycle after its push. With out_ready held high the
// queue never holds more than two tokens (a pair only follows a character that
// pushed at most one), so a character is taken every cycle; tokens leave one per cycle.
// Reset (rst_n low, asynchronous) empties the queue and the input register,
// closes any open word and sets the line count to 1.
// A stalled output holds the queue head; input stalls once the queue cannot
// take a full pair while the input register is still loaded.
module char_stream_lexer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  ch,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [clx_pkg::KIND_W-1:0]  kind,
    output logic [clx_pkg::LINE_W-1:0]  line_no,
    output logic [clx_pkg::LEN_W-1:0]   lexeme_len,
    output logic [clx_pkg::HEAD_W-1:0]  lexeme_head,
    output logic                        last
);
    import clx_pkg::*;

    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] ch_reg;
    logic       room;
    logic       fire;
    push_t      push;
    tok_t       out_tok;

    // The held character is processed only when the queue can take a pair
    assign fire     = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || fire;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_valid && in_ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg <= ch;
        end
    end

    clx_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (ch_reg),
        .push  (push)
    );

    clx_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_tok   (out_tok)
    );

    assign kind        = out_tok.kind;
    assign line_no     = out_tok.line_no;
    assign lexeme_len  = out_tok.len;
    assign lexeme_head = out_tok.head;
    assign last        = out_tok.last;

`ifndef SYNTH
    a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> fire)
        else $error("tokens pushed without a processed character");
    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !(in_valid && in_ready) |=> !stage_valid_reg)
        else $error("input register not released after processing");
    a_held_stage: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !fire |=> stage_valid_reg && $stable(ch_reg))
        else $error("held character lost");
`endif

endmodule

@@ bench/char_stream_lexer_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for char_stream_lexer_unit: drives characters, predicts tokens.
// Depends on clx_pkg (token kinds, character codes, widths) and the unit itself.
module char_stream_lexer_unit_tb;
    import clx_pkg::*;

    localparam int QUIET_LIMIT  = 1000;  // cycles with no request moved before giving up
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_CHARS = 550;

    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_UP_A = "A";

    typedef enum logic [1:0] {W_NONE, W_NUMBER, W_NAME} word_mode_e;

    // Running-word model plus the queue of tokens still owed by the unit.
    class token_ledger;
        tok_t        due_tokens[$];
        int          bad_tokens;
        word_mode_e  word_mode;
        bit          period_seen;
        logic [LEN_W-1:0]  word_len;
        logic [HEAD_W-1:0] word_head;
        logic [6:0]  kw_alive;
        logic [LINE_W-1:0] line_count;
        string       kw_text[7];
        kind_t       kw_kind[7];

        function new();
            kw_text     = '{"int", "char", "string", "float", "if", "else", "fn"};
            kw_kind     = '{K_VARTYPE, K_VARTYPE, K_VARTYPE, K_VARTYPE,
                            K_IF, K_ELSE, K_FUNCTION};
            bad_tokens  = 0;
            word_mode   = W_NONE;
            period_seen = 1'b0;
            word_len    = '0;
            word_head   = '0;
            kw_alive    = '1;
            line_count  = 1;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_name_start(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
        endfunction

        function bit is_word_char(logic [7:0] c);
            return is_digit(c) || is_name_start(c);
        endfunction

        function kind_t symbol_kind(logic [7:0] c);
            case (c)
                CH_LPAREN: return K_LPAREN;
                CH_RPAREN: return K_RPAREN;
                CH_LBRACE: return K_LBRACE;
                CH_RBRACE: return K_RBRACE;
                CH_COLON:  return K_COLON;
                CH_EQUALS: return K_EQUALS;
                default:   return K_OTHER;
            endcase
        endfunction

        function kind_t word_kind();
            if (word_mode == W_NUMBER)
                return K_NUMBER;
            for (int i = 0; i < 7; i++)
                if (kw_alive[i] && word_len == kw_text[i].len())
                    return kw_kind[i];
            return K_NAME;
        endfunction

        // Append one byte: fill the head, prune keyword candidates, saturate the length.
        function void add_char(logic [7:0] c);
            int p;
            p = word_len;
            if (p < HEAD_BYTES)
                word_head[8*p +: 8] = c;
            for (int i = 0; i < 7; i++)
                if (p >= kw_text[i].len() || kw_text[i][p] != c)
                    kw_alive[i] = 1'b0;
            if (word_len < MAX_WORD)
                word_len = word_len + 1'b1;
        endfunction

        function void open_word(logic [7:0] c);
            word_mode   = is_digit(c) ? W_NUMBER : W_NAME;
            period_seen = 1'b0;
            word_len    = '0;
            word_head   = '0;
            kw_alive    = '1;
            add_char(c);
        endfunction

        function tok_t make_tok(kind_t k, logic [LEN_W-1:0] len, logic [HEAD_W-1:0] head);
            tok_t t;
            t.kind    = k;
            t.line_no = line_count;
            t.len     = len;
            t.head    = head;
            t.last    = 1'b0;
            return t;
        endfunction

        // Called once per accepted input request.
        function void take_char(logic [7:0] c);
            tok_t       made[$];
            bit         blank;
            bit         grows;
            word_mode_e was;
            blank = (c == CH_SPACE || c == CH_NL);
            if (word_mode == W_NONE)
            begin
                if (is_word_char(c))
                    open_word(c);
                else if (!blank)
                    made.push_back(make_tok(symbol_kind(c), 1, HEAD_W'(c)));
            end
            else
            begin
                if (word_mode == W_NUMBER)
                    grows = is_digit(c) || (c == CH_PERIOD && !period_seen);
                else
                    grows = is_word_char(c);
                if (grows)
                begin
                    if (c == CH_PERIOD)
                        period_seen = 1'b1;
                    add_char(c);
                end
                else
                begin
                    was = word_mode;
                    made.push_back(make_tok(word_kind(), word_len, word_head));
                    word_mode   = W_NONE;
                    period_seen = 1'b0;
                    word_len    = '0;
                    word_head   = '0;
                    kw_alive    = '1;
                    // a letter closing a number starts a name, no symbol
                    if (was == W_NUMBER && is_name_start(c))
                        open_word(c);
                    else if (!blank)
                        made.push_back(make_tok(symbol_kind(c), 1, HEAD_W'(c)));
                end
            end
            if (made.size() > 0)
                made[made.size()-1].last = 1'b1;
            foreach (made[i])
                due_tokens.push_back(made[i]);
            if (c == CH_NL && line_count != '1)
                line_count = line_count + 1'b1;
        endfunction

        // Called once per accepted output request.
        function void match_token(tok_t got);
            tok_t want;
            if (due_tokens.size() == 0)
            begin
                bad_tokens++;
                if (bad_tokens <= 10)
                    $display("%0t: unexpected token kind %0d line %0d len %0d head %h last %0d",
                             $time, got.kind, got.line_no, got.len, got.head, got.last);
                return;
            end
            want = due_tokens.pop_front();
            if (got.kind != want.kind || got.line_no !== want.line_no ||
                got.len !== want.len || got.head !== want.head || got.last !== want.last)
            begin
                bad_tokens++;
                if (bad_tokens <= 10)
                    $display("%0t: token mismatch (exp/got) kind %0d/%0d line %0d/%0d len %0d/%0d",
                             $time, want.kind, got.kind, want.line_no, got.line_no,
                             want.len, got.len);
                if (bad_tokens <= 10)
                    $display("    head %h/%h last %0d/%0d", want.head, got.head,
                             want.last, got.last);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          ch = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [LINE_W-1:0]   line_no;
    logic [LEN_W-1:0]    lexeme_len;
    logic [HEAD_W-1:0]   lexeme_head;
    logic                last;

    token_ledger ledger = new();
    bit          idle_on = 1'b0;
    int          chars_sent = 0;
    int          stall_left = 0;

    string kw_pool[15] = '{"int", "char", "string", "float", "if", "else", "fn",
                           "in", "fnx", "iff", "els", "strings", "floa", "Int", "_if"};
    logic [7:0] sym_pool[8] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                CH_COLON, CH_EQUALS, CH_PERIOD, CH_TAB};

    char_stream_lexer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .line_no     (line_no),
        .lexeme_len  (lexeme_len),
        .lexeme_head (lexeme_head),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output side: random back-pressure bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tok_t got;
        got.kind    = kind_t'(kind);
        got.line_no = line_no;
        got.len     = lexeme_len;
        got.head    = lexeme_head;
        got.last    = last;
        if (rst_n && out_valid && out_ready)
            ledger.match_token(got);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Called at a clock edge; returns at the edge where the request was taken.
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        do @(posedge clk); while (!in_ready);
        ledger.take_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_char(s[i]);
    endtask

    // Hold the input off until every predicted token has been seen.
    task automatic drain_tokens();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.due_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] name_start_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CH_LOW_A + 8'(r);
        else if (r < 52)
            return CH_UP_A + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] word_char();
        if ($urandom_range(0, 3) == 0)
            return CH_ZERO + 8'($urandom_range(0, 9));
        return name_start_char();
    endfunction

    task automatic send_number(input int digits);
        repeat (digits)
            send_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // One lexical piece with random content, then maybe a blank.
    task automatic send_piece();
        int pick;
        int sep;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            send_text(kw_pool[$urandom_range(0, 14)]);
        end
        else if (pick < 45)
        begin
            send_char(name_start_char());
            repeat ($urandom_range(0, 11))
                send_char(word_char());
        end
        else if (pick < 65)
        begin
            send_number($urandom_range(1, 6));
            if ($urandom_range(0, 1) == 1)
            begin
                send_char(CH_PERIOD);
                send_number($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0)
                    send_char(CH_PERIOD);   // second period closes the number
            end
            if ($urandom_range(0, 4) == 0)
                send_char(name_start_char());
        end
        else if (pick < 80)
        begin
            send_char(sym_pool[$urandom_range(0, 7)]);
        end
        else if (pick < 92)
        begin
            send_char(8'($urandom_range(0, 255)));
        end
        sep = $urandom_range(0, 9);
        if (sep < 6)
            send_char(CH_SPACE);
        else if (sep < 8)
            send_char(CH_NL);
    endtask

    initial
    begin : stimulus
        int pieces;
        int goal;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keywords, second period, letter after number, all symbol kinds,
        // tab / CR / high bytes / NUL as other symbols, newline
        send_text("if int(1.5.3a_)\t{fn:=}");
        send_char(8'h0D);
        send_char(8'h80);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(CH_NL);
        drain_tokens();

        goal   = chars_sent + RANDOM_CHARS;
        pieces = 0;
        idle_on = 1'b1;
        while (chars_sent < goal - 120)
        begin
            if (pieces % 16 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_piece();
            pieces++;
        end

        // tail of the run at full rate on both sides
        idle_on = 1'b0;
        while (chars_sent < goal)
            send_piece();
        drain_tokens();

        // tokens on two lines, then a word left open at the end
        send_text("x y( 42\nelse:tail");
        in_valid <= 1'b0;

        while (ledger.due_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.bad_tokens == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/clx_pkg.sv
rtl/clx_core.sv
rtl/clx_tok_fifo.sv
rtl/char_stream_lexer_unit.sv
bench/char_stream_lexer_unit_tb.sv
